// ----- sv/image_fit_rect_mapper_macros.svh -----
// Assertion helpers for the image fit rectangle mapper.
// Plain header, no dependencies; included by the modules that assert.
`ifndef IMAGE_FIT_RECT_MAPPER_MACROS_SVH
`define IMAGE_FIT_RECT_MAPPER_MACROS_SVH

// same-cycle implication, disabled during reset
`define IMFIT_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define IMFIT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- sv/imfit_pkg.sv -----
// Shared types, constants and helpers for the image fit rectangle mapper.
// No dependencies; imported by imfit_div and image_fit_rect_mapper.
package imfit_pkg;

	localparam int FRAC_BITS_DEF = 8;
	localparam int COORD_W       = 32;
	localparam int TEXSZ_W       = 23;
	localparam int SCALE_W       = 12;
	localparam int DIV_BITS      = 64;
	localparam int DEN_W         = 32;
	localparam int SAT_IN_W      = 68;

	localparam logic [SCALE_W-1:0] SCALE_RESET = 12'd256;

	localparam logic [1:0] FIT_STRETCH = 2'd0;
	localparam logic [1:0] FIT_COVER   = 2'd1;
	localparam logic [1:0] FIT_CONTAIN = 2'd2;

	localparam logic [2:0] OP_NONE   = 3'd0;
	localparam logic [2:0] OP_CROP_W = 3'd1;
	localparam logic [2:0] OP_CROP_H = 3'd2;
	localparam logic [2:0] OP_FIT_W  = 3'd3;
	localparam logic [2:0] OP_FIT_H  = 3'd4;

	typedef struct packed {
		logic signed [COORD_W-1:0] box_x;
		logic signed [COORD_W-1:0] box_y;
		logic signed [COORD_W-1:0] box_w;
		logic signed [COORD_W-1:0] box_h;
		logic [TEXSZ_W-1:0]        tex_w;
		logic [TEXSZ_W-1:0]        tex_h;
		logic                      use_sub;
		logic signed [COORD_W-1:0] sub_x;
		logic signed [COORD_W-1:0] sub_y;
		logic signed [COORD_W-1:0] sub_w;
		logic signed [COORD_W-1:0] sub_h;
		logic [1:0]                fit_mode;
	} req_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] src_x;
		logic signed [COORD_W-1:0] src_y;
		logic signed [COORD_W-1:0] src_w;
		logic signed [COORD_W-1:0] src_h;
		logic signed [COORD_W-1:0] dst_x;
		logic signed [COORD_W-1:0] dst_y;
		logic signed [COORD_W-1:0] dst_w;
		logic signed [COORD_W-1:0] dst_h;
	} rsp_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] sx;
		logic signed [COORD_W-1:0] sy;
		logic signed [COORD_W-1:0] sw;
		logic signed [COORD_W-1:0] sh;
		logic signed [COORD_W-1:0] dx;
		logic signed [COORD_W-1:0] dy;
		logic signed [COORD_W-1:0] dw;
		logic signed [COORD_W-1:0] dh;
	} rect_t;

	typedef struct packed {
		rect_t      rect;
		logic [2:0] op;
		logic       neg;
	} side_t;

	function automatic logic signed [COORD_W-1:0] sat32(input logic signed [SAT_IN_W-1:0] v);
		logic signed [SAT_IN_W-1:0] hi;
		logic signed [SAT_IN_W-1:0] lo;
		hi = SAT_IN_W'(64'sd2147483647);
		lo = SAT_IN_W'(-64'sd2147483648);
		if (v > hi)
			return COORD_W'(hi);
		else if (v < lo)
			return COORD_W'(lo);
		else
			return COORD_W'(v);
	endfunction

endpackage

// ----- sv/imfit_div.sv -----
// Pipelined unsigned restoring divider, one quotient bit per stage.
// Depends on imfit_pkg; carries an opaque side vector alongside.
module imfit_div import imfit_pkg::*; #(
	parameter int NUM_W  = DIV_BITS,
	parameter int SIDE_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [NUM_W-1:0]  in_num,
	input  logic [DEN_W-1:0]  in_den,
	input  logic [SIDE_W-1:0] in_side,
	output logic              out_valid,
	output logic [NUM_W-1:0]  out_quo,
	output logic [SIDE_W-1:0] out_side
);

	logic [NUM_W-1:0]  vld_s;
	logic [DEN_W-1:0]  rem_s  [NUM_W];
	logic [NUM_W-1:0]  nq_s   [NUM_W];
	logic [DEN_W-1:0]  den_s  [NUM_W];
	logic [SIDE_W-1:0] side_s [NUM_W];

	logic [DEN_W-1:0]  rem_in  [NUM_W];
	logic [NUM_W-1:0]  nq_in   [NUM_W];
	logic [DEN_W-1:0]  den_in  [NUM_W];
	logic [SIDE_W-1:0] side_in [NUM_W];
	logic [DEN_W:0]    trial   [NUM_W];
	logic [NUM_W-1:0]  ge;
	logic [DEN_W-1:0]  rem_nx  [NUM_W];

	always_comb begin
		rem_in[0]  = '0;
		nq_in[0]   = in_num;
		den_in[0]  = in_den;
		side_in[0] = in_side;
		for (int k = 1; k < NUM_W; k++) begin
			rem_in[k]  = rem_s[k-1];
			nq_in[k]   = nq_s[k-1];
			den_in[k]  = den_s[k-1];
			side_in[k] = side_s[k-1];
		end
		for (int k = 0; k < NUM_W; k++) begin
			trial[k]  = {rem_in[k], nq_in[k][NUM_W-1]};
			ge[k]     = trial[k] >= {1'b0, den_in[k]};
			rem_nx[k] = ge[k] ? DEN_W'(trial[k] - {1'b0, den_in[k]}) : trial[k][DEN_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s <= '0;
		else if (en)
			vld_s <= {vld_s[NUM_W-2:0], in_valid};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < NUM_W; k++) begin
				rem_s[k]  <= rem_nx[k];
				nq_s[k]   <= {nq_in[k][NUM_W-2:0], ge[k]};
				den_s[k]  <= den_in[k];
				side_s[k] <= side_in[k];
			end
		end
	end

	assign out_valid = vld_s[NUM_W-1];
	assign out_quo   = nq_s[NUM_W-1];
	assign out_side  = side_s[NUM_W-1];

endmodule

// ----- sv/image_fit_rect_mapper.sv -----
// Image fit rectangle mapper: source and device destination rectangles per draw.
// Depends on imfit_pkg, imfit_div and image_fit_rect_mapper_macros.svh.
//
// Usage:
//   Request channel req/req_valid/req_stall carries one draw command; it is
//   taken at a clock edge with req_valid high and req_stall low.
//   Response channel rsp/rsp_valid/rsp_stall returns one result per request,
//   in order; the receiver holds rsp_stall high to keep a result waiting.
//   device_scale_we/device_scale_wdata write the scale register (Q4.8); write it
//   only while no request is in flight (the block itself does not enforce this).
// Timing:
//   A request is accepted every cycle while req_stall is low; its result shows on rsp
//   after the request, scaling, rescale and multiply stages, the divider (one quotient
//   bit per stage over 64 stages), the fit and snap stages and the output register.
//   When the receiver stalls, the waiting result is held and one more result
//   parks in a skid register; req_stall then rises until it drains.
// Reset:
//   arst_n clears all valid bits, empties the pipe and sets the scale to 1.0.
`include "image_fit_rect_mapper_macros.svh"
module image_fit_rect_mapper import imfit_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               device_scale_we,
	input  logic [SCALE_W-1:0] device_scale_wdata,
	input  logic               req_valid,
	output logic               req_stall,
	input  req_t               req,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output rsp_t               rsp
);

	localparam int PW = COORD_W + SCALE_W + 1;

	logic [SCALE_W-1:0] scale_q;
	logic               pipe_en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			scale_q <= SCALE_RESET;
		else if (device_scale_we)
			scale_q <= device_scale_wdata;
	end

	// stage 1: request register
	logic v_s1;
	req_t req_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (pipe_en)
			v_s1 <= req_valid;
	end

	always_ff @(posedge clk) begin
		if (pipe_en)
			req_s1 <= req;
	end

	// stage 2: scale products, source select
	logic                      v_s2;
	logic signed [PW-1:0]      pbx_s2, pby_s2, pbw_s2, pbh_s2;
	logic signed [COORD_W-1:0] sx_s2, sy_s2, sw_s2, sh_s2, bw_s2, bh_s2;
	logic [1:0]                mode_s2;
	logic signed [SCALE_W:0]   sc_ext;

	assign sc_ext = $signed({1'b0, scale_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s2 <= 1'b0;
		else if (pipe_en)
			v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			pbx_s2  <= req_s1.box_x * sc_ext;
			pby_s2  <= req_s1.box_y * sc_ext;
			pbw_s2  <= req_s1.box_w * sc_ext;
			pbh_s2  <= req_s1.box_h * sc_ext;
			bw_s2   <= req_s1.box_w;
			bh_s2   <= req_s1.box_h;
			mode_s2 <= req_s1.fit_mode;
			if (req_s1.use_sub) begin
				sx_s2 <= req_s1.sub_x;
				sy_s2 <= req_s1.sub_y;
				sw_s2 <= req_s1.sub_w;
				sh_s2 <= req_s1.sub_h;
			end else begin
				sx_s2 <= '0;
				sy_s2 <= '0;
				sw_s2 <= $signed(COORD_W'(req_s1.tex_w));
				sh_s2 <= $signed(COORD_W'(req_s1.tex_h));
			end
		end
	end

	// stage 3: truncating rescale, fit operands
	function automatic logic signed [COORD_W-1:0] scale_dn(input logic signed [PW-1:0] p);
		logic signed [PW:0] bias;
		logic signed [PW:0] t;
		bias = p[PW-1] ? (PW+1)'((1 << FRAC_BITS) - 1) : '0;
		t    = (PW+1)'(p) + bias;
		return sat32(SAT_IN_W'(t >>> FRAC_BITS));
	endfunction

	logic                      v_s3;
	rect_t                     rc_s3;
	logic signed [COORD_W-1:0] bw_s3, bh_s3, x1_s3, y1_s3, x2_s3, y2_s3;
	logic                      cover_s3, contain_s3;
	logic signed [COORD_W-1:0] dx_c, dy_c, dw_c, dh_c;
	logic                      cover_c, contain_c;

	always_comb begin
		dx_c      = scale_dn(pbx_s2);
		dy_c      = scale_dn(pby_s2);
		dw_c      = scale_dn(pbw_s2);
		dh_c      = scale_dn(pbh_s2);
		cover_c   = (mode_s2 == FIT_COVER) && (bw_s2 > 0) && (bh_s2 > 0) &&
			(sw_s2 != 0) && (sh_s2 != 0);
		contain_c = (mode_s2 == FIT_CONTAIN) && (sw_s2 > 0) && (sh_s2 > 0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s3 <= 1'b0;
		else if (pipe_en)
			v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			rc_s3      <= '{sx: sx_s2, sy: sy_s2, sw: sw_s2, sh: sh_s2,
				dx: dx_c, dy: dy_c, dw: dw_c, dh: dh_c};
			bw_s3      <= bw_s2;
			bh_s3      <= bh_s2;
			cover_s3   <= cover_c;
			contain_s3 <= contain_c;
			// cover: sw*bh vs bw*sh; contain: dw*sh vs dh*sw
			x1_s3      <= cover_c ? sw_s2 : sh_s2;
			y1_s3      <= cover_c ? bh_s2 : dw_c;
			x2_s3      <= cover_c ? sh_s2 : sw_s2;
			y2_s3      <= cover_c ? bw_s2 : dh_c;
		end
	end

	// stage 4: cross products
	logic                        v_s4;
	rect_t                       rc_s4;
	logic signed [COORD_W-1:0]   bw_s4, bh_s4;
	logic                        cover_s4, contain_s4;
	logic signed [2*COORD_W-1:0] p1_s4, p2_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s4 <= 1'b0;
		else if (pipe_en)
			v_s4 <= v_s3;
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			rc_s4      <= rc_s3;
			bw_s4      <= bw_s3;
			bh_s4      <= bh_s3;
			cover_s4   <= cover_s3;
			contain_s4 <= contain_s3;
			p1_s4      <= x1_s3 * y1_s3;
			p2_s4      <= x2_s3 * y2_s3;
		end
	end

	// compare and pick the division
	logic signed [2*COORD_W-1:0] num_c;
	logic [DEN_W-1:0]            den_c;
	logic [2:0]                  op_c;
	logic                        wider_c;
	side_t                       side_c;
	logic [DIV_BITS-1:0]         mag_c;

	always_comb begin
		wider_c = (rc_s4.sh > 0) ? (p1_s4 > p2_s4) : (p1_s4 < p2_s4);
		num_c   = p1_s4;
		den_c   = DEN_W'(1);
		op_c    = OP_NONE;
		if (cover_s4) begin
			if (wider_c) begin
				num_c = p2_s4;
				den_c = DEN_W'(bh_s4);
				op_c  = OP_CROP_W;
			end else begin
				num_c = p1_s4;
				den_c = DEN_W'(bw_s4);
				op_c  = OP_CROP_H;
			end
		end else if (contain_s4) begin
			if (p1_s4 <= p2_s4) begin
				num_c = p1_s4;
				den_c = DEN_W'(rc_s4.sw);
				op_c  = OP_FIT_W;
			end else begin
				num_c = p2_s4;
				den_c = DEN_W'(rc_s4.sh);
				op_c  = OP_FIT_H;
			end
		end
		mag_c       = num_c[2*COORD_W-1] ? DIV_BITS'(-num_c) : DIV_BITS'(num_c);
		side_c.rect = rc_s4;
		side_c.op   = op_c;
		side_c.neg  = num_c[2*COORD_W-1];
	end

	logic                        v_dv;
	logic [DIV_BITS-1:0]         quo_dv;
	logic [$bits(side_t)-1:0]    side_raw_dv;
	side_t                       side_dv;

	imfit_div #(
		.NUM_W  (DIV_BITS),
		.SIDE_W ($bits(side_t))
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (pipe_en),
		.in_valid  (v_s4),
		.in_num    (mag_c),
		.in_den    (den_c),
		.in_side   (side_c),
		.out_valid (v_dv),
		.out_quo   (quo_dv),
		.out_side  (side_raw_dv)
	);

	assign side_dv = side_t'(side_raw_dv);

	// fit stage: new size and centered origin
	logic signed [DIV_BITS:0]   qs_c;
	logic signed [COORD_W-1:0]  base_c, full_c, nsz_c, norg_c;
	logic signed [DIV_BITS+1:0] diff_c, half_c;
	logic signed [DIV_BITS+2:0] sum_c;
	rect_t                      fit_c;

	always_comb begin
		qs_c = side_dv.neg ? -$signed({1'b0, quo_dv}) : $signed({1'b0, quo_dv});
		case (side_dv.op)
			OP_CROP_W: begin base_c = side_dv.rect.sx; full_c = side_dv.rect.sw; end
			OP_CROP_H: begin base_c = side_dv.rect.sy; full_c = side_dv.rect.sh; end
			OP_FIT_W:  begin base_c = side_dv.rect.dy; full_c = side_dv.rect.dh; end
			OP_FIT_H:  begin base_c = side_dv.rect.dx; full_c = side_dv.rect.dw; end
			default:   begin base_c = '0; full_c = '0; end
		endcase
		diff_c = (DIV_BITS+2)'(full_c) - (DIV_BITS+2)'(qs_c);
		half_c = (diff_c + $signed((DIV_BITS+2)'(diff_c[DIV_BITS+1]))) >>> 1;
		sum_c  = (DIV_BITS+3)'(base_c) + (DIV_BITS+3)'(half_c);
		nsz_c  = sat32(SAT_IN_W'(qs_c));
		norg_c = sat32(SAT_IN_W'(sum_c));
		fit_c  = side_dv.rect;
		case (side_dv.op)
			OP_CROP_W: begin fit_c.sx = norg_c; fit_c.sw = nsz_c; end
			OP_CROP_H: begin fit_c.sy = norg_c; fit_c.sh = nsz_c; end
			OP_FIT_W:  begin fit_c.dy = norg_c; fit_c.dh = nsz_c; end
			OP_FIT_H:  begin fit_c.dx = norg_c; fit_c.dw = nsz_c; end
			default:   fit_c = side_dv.rect;
		endcase
	end

	logic  v_ft;
	rect_t fit_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_ft <= 1'b0;
		else if (pipe_en)
			v_ft <= v_dv;
	end

	always_ff @(posedge clk) begin
		if (pipe_en)
			fit_s <= fit_c;
	end

	// snap stage: near 1:1 draws land on whole pixels
	localparam logic signed [COORD_W:0] HALF_PX = (COORD_W+1)'(1 << (FRAC_BITS - 1));
	localparam logic [COORD_W:0]        PX_MASK = (COORD_W+1)'((1 << FRAC_BITS) - 1);

	logic signed [COORD_W:0] ddw_c, ddh_c, adw_c, adh_c, rx_c, ry_c;
	logic                    snap_c;
	rsp_t                    snap_rsp_c;

	always_comb begin
		ddw_c  = (COORD_W+1)'(fit_s.dw) - (COORD_W+1)'(fit_s.sw);
		ddh_c  = (COORD_W+1)'(fit_s.dh) - (COORD_W+1)'(fit_s.sh);
		adw_c  = ddw_c[COORD_W] ? -ddw_c : ddw_c;
		adh_c  = ddh_c[COORD_W] ? -ddh_c : ddh_c;
		snap_c = (adw_c < HALF_PX) && (adh_c < HALF_PX);
		rx_c   = ((COORD_W+1)'(fit_s.dx) + HALF_PX) & ~PX_MASK;
		ry_c   = ((COORD_W+1)'(fit_s.dy) + HALF_PX) & ~PX_MASK;
		snap_rsp_c.src_x = fit_s.sx;
		snap_rsp_c.src_y = fit_s.sy;
		snap_rsp_c.src_w = fit_s.sw;
		snap_rsp_c.src_h = fit_s.sh;
		if (snap_c) begin
			snap_rsp_c.dst_x = sat32(SAT_IN_W'(rx_c));
			snap_rsp_c.dst_y = sat32(SAT_IN_W'(ry_c));
			snap_rsp_c.dst_w = fit_s.sw;
			snap_rsp_c.dst_h = fit_s.sh;
		end else begin
			snap_rsp_c.dst_x = fit_s.dx;
			snap_rsp_c.dst_y = fit_s.dy;
			snap_rsp_c.dst_w = fit_s.dw;
			snap_rsp_c.dst_h = fit_s.dh;
		end
	end

	logic v_lst;
	rsp_t rsp_lst;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_lst <= 1'b0;
		else if (pipe_en)
			v_lst <= v_ft;
	end

	always_ff @(posedge clk) begin
		if (pipe_en)
			rsp_lst <= snap_rsp_c;
	end

	// output register plus skid
	logic out_valid_q, skid_valid_q, xfer;
	rsp_t out_q, skid_q;

	assign pipe_en   = !skid_valid_q;
	assign req_stall = skid_valid_q;
	assign xfer      = v_lst && pipe_en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || !rsp_stall) begin
			out_valid_q  <= skid_valid_q || xfer;
			skid_valid_q <= 1'b0;
		end else if (xfer) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || !rsp_stall)
			out_q <= skid_valid_q ? skid_q : rsp_lst;
		else if (xfer)
			skid_q <= rsp_lst;
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

	`IMFIT_ASSERT_IMPL(a_skid_needs_out, clk, arst_n, skid_valid_q, out_valid_q, "skid holds data with empty output")
	`IMFIT_ASSERT_IMPL(a_skid_fill_on_stall, clk, arst_n, $rose(skid_valid_q), $past(out_valid_q && rsp_stall), "skid filled without a stall")
	`IMFIT_ASSERT_NEXT(a_skid_drains, clk, arst_n, skid_valid_q && !rsp_stall, !skid_valid_q, "skid did not drain")
	`IMFIT_ASSERT_NEXT(a_frozen_holds, clk, arst_n, !pipe_en && v_lst, v_lst, "frozen pipe lost its last item")

endmodule
